>>> rtl/core/b64e_pkg.sv
package b64e_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } t_out_item;

    localparam int          GROUP_CHARS = 4;
    localparam logic [7:0]  PAD_CHAR    = 8'h3D;

    typedef struct packed {
        logic [GROUP_CHARS-1:0][7:0] chars;
        logic [1:0]                  last_idx;
        logic                        ends_msg;
    } t_group;

    typedef enum logic [2:0] {
        PH_FIRST  = 3'b001,
        PH_SECOND = 3'b010,
        PH_THIRD  = 3'b100
    } t_phase;

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            return 8'(8'd65 + w);
        end else if (v < 6'd52) begin
            return 8'(8'd71 + w);
        end else if (v < 6'd62) begin
            return 8'(w - 8'd4);
        end else if (v == 6'd62) begin
            return 8'h2B;
        end else begin
            return 8'h2F;
        end
    endfunction

endpackage

>>> rtl/core/base64_encoder_unit.sv
// Streaming Base64 encoder, standard alphabet with '=' padding.
// The input channel takes one raw byte per request, with end_of_message set
// on the final byte of a message. The output channel gives one ASCII
// character per request; last_char marks the final character of a message.
// Each byte is classified by its place in the three-byte group and turned at
// once into the one to four characters it completes; these wait in a small
// queue of QUEUE_DEPTH groups. The back end sends one character per cycle while
// the receiver is ready, so the sustained rate is set by that single output
// register; the queue lets new bytes be taken while earlier characters wait.
// An accepted byte's group is written into the queue, then its first character
// is loaded into the output register; when the receiver is ready each further
// character follows in the next cycle. When the receiver stalls, the current
// character holds and the queue fills, after which the input stops taking bytes.
// Reset clears the group position, the queue and the output valid, so the
// next byte starts a fresh message.
module base64_encoder_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  b64e_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output b64e_pkg::t_out_item o_out
);

    logic             q_push, q_ready, q_pop, q_valid;
    b64e_pkg::t_group q_wr_group, q_rd_group;

    b64e_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .i_q_ready  (q_ready),
        .o_q_push   (q_push),
        .o_q_group  (q_wr_group)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_group (q_wr_group),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_group (q_rd_group)
    );

    b64e_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_group   (q_rd_group),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

>>> rtl/core/b64e_front.sv
module b64e_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  b64e_pkg::t_in_item i_in,
    input  logic               i_q_ready,
    output logic               o_q_push,
    output b64e_pkg::t_group   o_q_group
);

    b64e_pkg::t_phase r_phase, n_phase;
    logic [3:0]       r_left, n_left;
    logic [7:0]       b;

    assign b          = i_in.data_byte;
    assign o_in_ready = i_q_ready;
    assign o_q_push   = i_in_valid && i_q_ready;

    always_comb begin
        n_phase   = r_phase;
        n_left    = r_left;
        o_q_group.chars    = '{default: b64e_pkg::PAD_CHAR};
        o_q_group.last_idx = 2'd0;
        o_q_group.ends_msg = i_in.end_of_message;
        case (r_phase)
            b64e_pkg::PH_SECOND: begin
                o_q_group.chars[0] = b64e_pkg::sextet_char({r_left[1:0], b[7:4]});
                if (i_in.end_of_message) begin
                    o_q_group.chars[1] = b64e_pkg::sextet_char({b[3:0], 2'b00});
                    o_q_group.last_idx = 2'd2;
                    n_phase = b64e_pkg::PH_FIRST;
                    n_left  = 4'd0;
                end else begin
                    n_phase = b64e_pkg::PH_THIRD;
                    n_left  = b[3:0];
                end
            end
            b64e_pkg::PH_THIRD: begin
                o_q_group.chars[0] = b64e_pkg::sextet_char({r_left, b[7:6]});
                o_q_group.chars[1] = b64e_pkg::sextet_char(b[5:0]);
                o_q_group.last_idx = 2'd1;
                n_phase = b64e_pkg::PH_FIRST;
                n_left  = 4'd0;
            end
            default: begin
                o_q_group.chars[0] = b64e_pkg::sextet_char(b[7:2]);
                if (i_in.end_of_message) begin
                    o_q_group.chars[1] = b64e_pkg::sextet_char({b[1:0], 4'b0000});
                    o_q_group.last_idx = 2'd3;
                    n_phase = b64e_pkg::PH_FIRST;
                    n_left  = 4'd0;
                end else begin
                    n_phase = b64e_pkg::PH_SECOND;
                    n_left  = {2'b00, b[1:0]};
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= b64e_pkg::PH_FIRST;
            r_left  <= 4'd0;
        end else if (o_q_push) begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

endmodule

>>> rtl/core/b64e_queue.sv
module b64e_queue #(
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  b64e_pkg::t_group i_group,
    output logic             o_ready,
    input  logic             i_pop,
    output logic             o_valid,
    output b64e_pkg::t_group o_group
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b64e_pkg::t_group r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_group = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : PW'(r_wr_ptr + 1'b1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : PW'(r_rd_ptr + 1'b1);
            end
            if (do_push && !do_pop) begin
                r_count <= CW'(r_count + 1'b1);
            end else if (do_pop && !do_push) begin
                r_count <= CW'(r_count - 1'b1);
            end
        end
    end

endmodule

>>> rtl/core/b64e_back.sv
module b64e_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  b64e_pkg::t_group    i_q_group,
    output logic                o_q_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output b64e_pkg::t_out_item o_out
);

    logic                r_out_valid;
    b64e_pkg::t_out_item r_out;
    logic [1:0]          r_idx;
    logic                load, at_end;

    assign load    = i_q_valid && (!r_out_valid || i_out_ready);
    assign at_end  = (r_idx == i_q_group.last_idx);
    assign o_q_pop = load && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= 2'd0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_idx       <= at_end ? 2'd0 : 2'(r_idx + 1'b1);
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.out_char  <= i_q_group.chars[r_idx];
            r_out.last_char <= at_end && i_q_group.ends_msg;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> rtl/core/b64e_checker.sv
module b64e_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input b64e_pkg::t_in_item  i_in,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input b64e_pkg::t_out_item o_out
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output valid seen after reset.");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("Stalled output request changed or dropped.");

    a_pad_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out.out_char == b64e_pkg::PAD_CHAR
            && !o_out.last_char
        |=> o_out_valid && o_out.out_char == b64e_pkg::PAD_CHAR && o_out.last_char)
        else $error("First padding character not followed by final padding.");

    a_in_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("Input stalled while no character is pending.");

endmodule

bind base64_encoder_unit b64e_checker u_b64e_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
